@@ hw/rtl/clt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Shared codes and defaults for the circular list table.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W       = 32;
  localparam int SLOT_W        = 6;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/clt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module clt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/circular_list_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// circular_list_table
// Bounded circular singly linked list of signed 32-bit values, held in a
// single node RAM, with insert, remove-first-match and search requests.
// ----------------------------------------------------------------------------
// One request at a time. A transaction is taken on a clock edge with start
// high and busy low; its single result appears for exactly one cycle with
// done high, and the receiver cannot stall it, so capture it on that cycle.
// An insert into a non-empty list scans the used flags from slot 0 up
// through the node RAM read port, one slot a cycle, then reads the tail and
// makes two link writes. An insert into an empty list answers from the scan.
// A remove or search walks the list from the head, one node read a cycle as
// the walk follows the links; a remove of a node from a list of two or more
// then spends one more state freeing the slot. Unused kinds, a full store on
// insert and a remove or search on an empty list answer on the next cycle.
// After reset the block clears every slot and holds busy high during that
// pass. Each node RAM word packs a used flag, the value and the link to the
// next slot; the tail slot and entry count live in registers.
// ----------------------------------------------------------------------------
module circular_list_table
  import clt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [1:0]                kind,
  input  wire logic signed [VALUE_W-1:0] value,
  output      logic                      busy,
  output      logic                      done,
  output      logic [1:0]                status,
  output      logic [SLOT_W-1:0]         slot
);

  localparam int AW = $clog2(DEPTH);     // slot address width
  localparam int CW = $clog2(DEPTH + 1); // entry count width
  localparam int NW = 1 + VALUE_W + AW;  // node word: used, value, link

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_INS_TAIL,
    S_INS_LINK,
    S_WALK_HEAD,
    S_WALK,
    S_FREE
  } state_t;

  state_t             state;
  logic [AW-1:0]      clr_addr;
  logic [1:0]         req_kind;
  logic [VALUE_W-1:0] req_value;
  logic [AW-1:0]      scan_addr;
  logic [AW-1:0]      free_slot;
  logic [AW-1:0]      tail_slot;
  logic [CW-1:0]      entry_count;
  logic [AW-1:0]      prev_slot;
  logic [VALUE_W-1:0] prev_value;
  logic [AW-1:0]      cur_slot;
  logic [CW-1:0]      steps;
  logic [VALUE_W-1:0] tail_value;

  // Node RAM port signals
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [NW-1:0]      wr_data;
  logic [AW-1:0]      rd_addr;
  logic [NW-1:0]      rd_data;

  logic               rd_used;
  logic [VALUE_W-1:0] rd_value;
  logic [AW-1:0]      rd_link;
  logic               rd_match;
  logic [CW-1:0]      steps_inc;

  assign rd_used   = rd_data[NW-1];
  assign rd_value  = rd_data[AW +: VALUE_W];
  assign rd_link   = rd_data[AW-1:0];
  assign rd_match  = (rd_value == req_value);
  assign steps_inc = steps + 1'b1;

  assign busy = (state != S_IDLE);

  // Slot number as reported: masked to the result field width.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [AW-1:0] s);
    logic [SLOT_W+AW-1:0] wide;
    wide = {{SLOT_W{1'b0}}, s};
    return wide[SLOT_W-1:0];
  endfunction

  clt_ram #(
    .WIDTH (NW),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read address: steer so that the word needed next cycle is on rd_data.
  always_comb begin
    rd_addr = tail_slot;
    unique case (state)
      S_IDLE: begin
        // Insert starts its free-slot scan at slot 0; walks start at the tail.
        rd_addr = (kind == KIND_INSERT) ? '0 : tail_slot;
      end
      S_SCAN: begin
        // Advance the scan, or fetch the tail once a free slot shows up.
        rd_addr = rd_used ? AW'(scan_addr + 1'b1) : tail_slot;
      end
      S_WALK_HEAD, S_WALK: begin
        rd_addr = rd_link;
      end
      default: begin
        rd_addr = tail_slot;
      end
    endcase
  end

  // Write port: at most one node word written per cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_slot;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      S_SCAN: begin
        // First node of an empty list links to itself.
        if (!rd_used && entry_count == '0) begin
          wr_en   = 1'b1;
          wr_addr = scan_addr;
          wr_data = {1'b1, req_value, scan_addr};
        end
      end
      S_INS_TAIL: begin
        // New node takes over the tail's link to the head.
        wr_en   = 1'b1;
        wr_addr = free_slot;
        wr_data = {1'b1, req_value, rd_link};
      end
      S_INS_LINK: begin
        // Old tail now points at the new node.
        wr_en   = 1'b1;
        wr_addr = tail_slot;
        wr_data = {1'b1, tail_value, free_slot};
      end
      S_WALK: begin
        if (rd_match && req_kind == KIND_REMOVE) begin
          wr_en = 1'b1;
          if (entry_count == CW'(1)) begin
            wr_addr = cur_slot;
          end else begin
            // Unlink: predecessor skips over the matched node.
            wr_addr = prev_slot;
            wr_data = {1'b1, prev_value, rd_link};
          end
        end
      end
      S_FREE: begin
        wr_en   = 1'b1;
        wr_addr = cur_slot;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, list registers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      tail_slot   <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= AW'(clr_addr + 1'b1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            req_kind  <= kind;
            req_value <= value;
            priority if (kind == KIND_INSERT) begin
              if (entry_count == CW'(DEPTH)) begin
                done   <= 1'b1;
                status <= ST_FULL;
                slot   <= '0;
              end else begin
                scan_addr <= '0;
                state     <= S_SCAN;
              end
            end else if (kind == KIND_REMOVE || kind == KIND_SEARCH) begin
              if (entry_count == '0) begin
                done   <= 1'b1;
                status <= ST_EMPTY;
                slot   <= '0;
              end else begin
                state <= S_WALK_HEAD;
              end
            end else begin
              done   <= 1'b1;
              status <= ST_NOTFOUND;
              slot   <= '0;
            end
          end
        end

        S_SCAN: begin
          if (rd_used) begin
            scan_addr <= AW'(scan_addr + 1'b1);
          end else begin
            free_slot <= scan_addr;
            if (entry_count == '0) begin
              tail_slot   <= scan_addr;
              entry_count <= CW'(1);
              done        <= 1'b1;
              status      <= ST_DONE;
              slot        <= to_slot(scan_addr);
              state       <= S_IDLE;
            end else begin
              state <= S_INS_TAIL;
            end
          end
        end

        S_INS_TAIL: begin
          tail_value <= rd_value;
          state      <= S_INS_LINK;
        end

        S_INS_LINK: begin
          tail_slot   <= free_slot;
          entry_count <= CW'(entry_count + 1'b1);
          done        <= 1'b1;
          status      <= ST_DONE;
          slot        <= to_slot(free_slot);
          state       <= S_IDLE;
        end

        S_WALK_HEAD: begin
          // rd_data holds the tail; its link is the head.
          prev_slot  <= tail_slot;
          prev_value <= rd_value;
          cur_slot   <= rd_link;
          steps      <= '0;
          state      <= S_WALK;
        end

        S_WALK: begin
          if (rd_match) begin
            if (req_kind == KIND_SEARCH) begin
              done   <= 1'b1;
              status <= ST_DONE;
              slot   <= to_slot(cur_slot);
              state  <= S_IDLE;
            end else if (entry_count == CW'(1)) begin
              // Last node gone: list empty, tail back to slot 0.
              tail_slot   <= '0;
              entry_count <= '0;
              done        <= 1'b1;
              status      <= ST_DONE;
              slot        <= to_slot(cur_slot);
              state       <= S_IDLE;
            end else begin
              if (cur_slot == tail_slot) begin
                tail_slot <= prev_slot;
              end
              entry_count <= CW'(entry_count - 1'b1);
              state       <= S_FREE;
            end
          end else if (steps_inc == entry_count) begin
            done   <= 1'b1;
            status <= ST_NOTFOUND;
            slot   <= '0;
            state  <= S_IDLE;
          end else begin
            steps      <= steps_inc;
            prev_slot  <= cur_slot;
            prev_value <= rd_value;
            cur_slot   <= rd_link;
          end
        end

        S_FREE: begin
          done   <= 1'b1;
          status <= ST_DONE;
          slot   <= to_slot(cur_slot);
          state  <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/clt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the circular list table, bound to the top level.
// ----------------------------------------------------------------------------
module clt_checker
  import clt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [1:0]        status,
  input wire logic [SLOT_W-1:0] slot
);

  // Result appears only once the block is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Any failure reports slot zero.
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (slot == '0))
    else $error("nonzero slot on failed request");

  // An accepted transaction either answers at once or starts work.
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted transaction dropped");

  // No result without a request in flight.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start && !busy)))
    else $error("result without a transaction");

endmodule

bind circular_list_table clt_checker u_clt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status),
  .slot   (slot)
);
`default_nettype wire

@@ bench/circular_list_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_list_table_tb
// Self-checking bench for the circular list table. A scoreboard keeps its own
// copy of the node store, the links and the tail, works out the answer to
// each accepted request and checks every done strobe against the oldest
// answer still awaited. Directed requests come first, then random requests
// in episodes that fill, churn and drain the list.
// ----------------------------------------------------------------------------
module circular_list_table_tb;
  import clt_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int RAND_ITEMS  = 1900;
  localparam int EPISODE_LEN = 150;
  localparam int MAX_GAP     = 14;
  // Cycles with nothing accepted before the run is called hung. The worst
  // correct stretch is the clearing pass after reset plus a full sender gap
  // plus the longest walk, all well under this.
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  typedef enum int {
    MODE_FILL,
    MODE_CHURN,
    MODE_DRAIN
  } episode_mode_t;

  // Scoreboard: mirror of the list plus the answers still awaited.
  class list_scoreboard;
    logic signed [VALUE_W-1:0] node_val [DEPTH];
    logic [SLOT_W-1:0]         node_next [DEPTH];
    bit                        slot_taken [DEPTH];
    logic [SLOT_W-1:0]         tail;
    int unsigned               entries;
    int unsigned               errors;
    answer_t                   awaited_answers [$];

    function new();
      foreach (slot_taken[i]) begin
        slot_taken[i] = 1'b0;
        node_val[i]   = '0;
        node_next[i]  = '0;
      end
      tail    = '0;
      entries = 0;
      errors  = 0;
    endfunction

    // Apply one accepted request to the mirror and queue its answer.
    function void note_request(kind_t k, logic signed [VALUE_W-1:0] v);
      answer_t           a;
      int unsigned       free_slot;
      int unsigned       walked;
      logic [SLOT_W-1:0] prev;
      logic [SLOT_W-1:0] cur;
      bit                found;
      a.status = ST_NOTFOUND;
      a.slot   = '0;
      found    = 1'b0;
      if (k == KIND_INSERT) begin
        free_slot = 0;
        for (int i = 0; i < DEPTH && !found; i++) begin
          if (!slot_taken[i]) begin
            free_slot = i;
            found     = 1'b1;
          end
        end
        if (!found) begin
          a.status = ST_FULL;
        end else begin
          node_val[free_slot]   = v;
          slot_taken[free_slot] = 1'b1;
          if (entries == 0) begin
            node_next[free_slot] = SLOT_W'(free_slot);
          end else begin
            node_next[free_slot] = node_next[tail];
            node_next[tail]      = SLOT_W'(free_slot);
          end
          tail = SLOT_W'(free_slot);
          entries++;
          a.status = ST_DONE;
          a.slot   = SLOT_W'(free_slot);
        end
      end else if (k == KIND_UNUSED) begin
        a.status = ST_NOTFOUND;
      end else if (entries == 0) begin
        a.status = ST_EMPTY;
      end else begin
        // Walk from the head, which is the node after the tail.
        prev = tail;
        cur  = node_next[tail];
        for (walked = 0; walked < entries && !found; walked++) begin
          if (node_val[cur] == v) begin
            found    = 1'b1;
            a.status = ST_DONE;
            a.slot   = cur;
            if (k == KIND_REMOVE) begin
              if (entries == 1) begin
                tail = '0;
              end else begin
                if (cur == tail) tail = prev;
                node_next[prev] = node_next[cur];
              end
              slot_taken[cur] = 1'b0;
              entries--;
            end
          end else begin
            prev = cur;
            cur  = node_next[cur];
          end
        end
      end
      awaited_answers.push_back(a);
    endfunction

    function void check_answer(logic [1:0] st, logic [SLOT_W-1:0] sl);
      answer_t a;
      if (awaited_answers.size() == 0) begin
        errors++;
        $error("result with no request awaiting it: status %0d slot %0d", st, sl);
        return;
      end
      a = awaited_answers.pop_front();
      if (st !== a.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", a.status, st);
      end
      if (sl !== a.slot) begin
        errors++;
        $error("slot: expected %0d, actual %0d", a.slot, sl);
      end
    endfunction

    // Value held in some slot on the list; call only with entries nonzero.
    function logic signed [VALUE_W-1:0] listed_value();
      int unsigned s;
      s = $urandom_range(0, DEPTH - 1);
      while (!slot_taken[s]) s = (s + 1) % DEPTH;
      return node_val[s];
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [1:0]                kind = KIND_INSERT;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      busy;
  logic                      done;
  logic [1:0]                status;
  logic [SLOT_W-1:0]         slot;

  list_scoreboard sb = new();
  bit             idle_enabled;
  int unsigned    stall_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  circular_list_table #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .value (value),
    .busy  (busy),
    .done  (done),
    .status(status),
    .slot  (slot)
  );

  // Present one request and hold it until the block takes the transaction.
  // The caller sits on a rising edge; start is only lowered when a gap is
  // drawn, so back-to-back transactions keep it high without a glitch.
  task automatic issue_request(kind_t k, logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    gap = idle_enabled ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    value <= v;
    @(posedge clk);
    // busy here is the value from the cycle just ended, so the edge above
    // took the transaction exactly when it was low.
    while (busy) @(posedge clk);
    sb.note_request(k, v);
  endtask

  // Half the values, with the list not empty, are on it so removes and searches
  // hit; the rest come from a small pool that breeds duplicates, or are random.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5 && sb.entries != 0) return sb.listed_value();
    if (r < 8) begin
      case ($urandom_range(0, 5))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return 32'sh0000_0000;
        3:       return -32'sd1;
        4:       return 32'sd5;
        default: return 32'sd6;
      endcase
    end
    return $urandom;
  endfunction

  function automatic kind_t pick_kind(episode_mode_t mode);
    int unsigned r;
    int unsigned insert_pct;
    int unsigned remove_pct;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        insert_pct = 75;
        remove_pct = 12;
      end
      MODE_DRAIN: begin
        insert_pct = 15;
        remove_pct = 65;
      end
      default: begin
        insert_pct = 40;
        remove_pct = 35;
      end
    endcase
    if (r < 3) return KIND_UNUSED;
    if (r < 3 + insert_pct) return KIND_INSERT;
    if (r < 3 + insert_pct + remove_pct) return KIND_REMOVE;
    return KIND_SEARCH;
  endfunction

  // Monitor: check every done strobe and watch for a hang. Outputs are read
  // at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && done) sb.check_answer(status, slot);
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    episode_mode_t mode;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty list, extremes, duplicates, head, middle and only
    // node removal, reuse of a freed slot, and the unused kind.
    idle_enabled = 1'b1;
    issue_request(KIND_SEARCH, 32'sd0);
    issue_request(KIND_REMOVE, 32'sd0);
    issue_request(KIND_UNUSED, -32'sd1);
    issue_request(KIND_INSERT, 32'sh8000_0000);
    issue_request(KIND_INSERT, 32'sh7FFF_FFFF);
    issue_request(KIND_INSERT, 32'sd0);
    issue_request(KIND_INSERT, -32'sd1);
    issue_request(KIND_INSERT, 32'sh7FFF_FFFF);
    issue_request(KIND_SEARCH, 32'sh7FFF_FFFF);
    issue_request(KIND_SEARCH, 32'sd12345);
    issue_request(KIND_REMOVE, 32'sd12345);
    issue_request(KIND_REMOVE, 32'sh7FFF_FFFF);
    issue_request(KIND_REMOVE, -32'sd1);
    issue_request(KIND_INSERT, 32'sd7);
    issue_request(KIND_SEARCH, 32'sd7);
    issue_request(KIND_UNUSED, 32'sh7FFF_FFFF);
    issue_request(KIND_REMOVE, 32'sh8000_0000);
    issue_request(KIND_REMOVE, 32'sd0);
    issue_request(KIND_REMOVE, 32'sh7FFF_FFFF);
    issue_request(KIND_REMOVE, 32'sd7);
    issue_request(KIND_SEARCH, 32'sd7);

    // Random part: episodes favour inserts to fill the store, a mix to churn it,
    // then removes to drain it. Idling is switched per episode so some run flat out.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % EPISODE_LEN == 0) begin
        case ((n / EPISODE_LEN) % 3)
          0:       mode = MODE_FILL;
          1:       mode = MODE_CHURN;
          default: mode = MODE_DRAIN;
        endcase
        idle_enabled = $urandom_range(0, 1);
      end
      issue_request(pick_kind(mode), pick_value());
    end
    start <= 1'b0;

    // Drain: wait for the last answer, then hold a walk's length for strays.
    while (sb.awaited_answers.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
